### hdl/cbts_pkg.sv
`default_nettype none

package cbts_pkg;

    // Field widths of the transactions.
    localparam int CLK_W    = 32;
    localparam int RATE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int PRE_W    = 11;
    localparam int SEG1_W   = 5;
    localparam int SEG2_W   = 4;
    localparam int SJW_W    = 1;
    localparam int WORD_W   = 26;

    // Search limits.
    localparam int MAX_PRESCALER = 1024;
    localparam int MAX_SEG_ONE   = 16;
    localparam int MAX_SEG_TWO   = 8;

    // Quanta per bit that can ever be legal, one remainder lane for each.
    localparam int QUANTA_MIN = 3;
    localparam int QUANTA_MAX = 1 + MAX_SEG_ONE + MAX_SEG_TWO;
    localparam int NUM_LANES  = QUANTA_MAX - QUANTA_MIN + 1;
    localparam int LANE_W     = $clog2(NUM_LANES);
    localparam int TQ_W       = $clog2(QUANTA_MAX + 1);

    // Any target above this bound has no solution.
    localparam int TARGET_W = $clog2(MAX_PRESCALER * QUANTA_MAX + 1);

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

    // Smallest legal segment one for each quanta count, zero when none fits.
    typedef logic [SEG1_W-1:0] t_seg_tab [0:QUANTA_MAX];

    function automatic t_seg_tab f_seg_one_tab();
        t_seg_tab tab;
        int       s2;
        for (int q = 0; q <= QUANTA_MAX; q++) begin
            tab[q] = '0;
            // Walk downward so that the smallest legal value is kept.
            for (int s1 = MAX_SEG_ONE; s1 >= 1; s1--) begin
                s2 = q - 1 - s1;
                if (q >= 2 + s1 && s2 >= 1 && s2 <= MAX_SEG_TWO &&
                    10 * (1 + s1) >= 7 * q && 10 * (1 + s1) <= 8 * q) begin
                    tab[q] = SEG1_W'(s1);
                end
            end
        end
        return tab;
    endfunction

    localparam t_seg_tab SEG_ONE_TAB = f_seg_one_tab();

endpackage

`default_nettype wire

### hdl/cbts_ifs.sv
`default_nettype none

// Request channel: clock frequency and requested bit rate.
interface cbts_in_if;
    logic                         valid;
    logic                         ready;
    logic [cbts_pkg::CLK_W-1:0]   clock_hz;
    logic [cbts_pkg::RATE_W-1:0]  bit_rate;

    modport source (output valid, output clock_hz, output bit_rate, input ready);
    modport sink   (input valid, input clock_hz, input bit_rate, output ready);
endinterface

// Result channel: status, timing fields and the packed timing word.
interface cbts_out_if;
    logic                           valid;
    logic                           ready;
    logic [cbts_pkg::STATUS_W-1:0]  status;
    logic [cbts_pkg::PRE_W-1:0]     prescaler;
    logic [cbts_pkg::SEG1_W-1:0]    segment_one;
    logic [cbts_pkg::SEG2_W-1:0]    segment_two;
    logic [cbts_pkg::SJW_W-1:0]     jump_width;
    logic [cbts_pkg::WORD_W-1:0]    timing_word;

    modport source (output valid, output status, output prescaler, output segment_one,
                    output segment_two, output jump_width, output timing_word,
                    input ready);
    modport sink   (input valid, input status, input prescaler, input segment_one,
                    input segment_two, input jump_width, input timing_word,
                    output ready);
endinterface

`default_nettype wire

### hdl/can_bit_timing_search.sv
`default_nettype none

// Channel   Direction  Interface    Contents
// i_in      sink       cbts_in_if   clock_hz, bit_rate
// o_out     source     cbts_out_if  status, prescaler, segment_one, segment_two,
//                                   jump_width, timing_word
//
// An accepted request runs through the restoring divider (S_DIV), which makes
// one quotient bit per cycle, and then through the timing pick (S_SEL). A zero
// clock or rate skips the divider and goes straight to the timing pick. A new
// request is taken only after the previous one has left the timing pick.
// Reset clears the state machine and the result valid flag.
// A result waits in the output register; the next request is taken meanwhile,
// and it holds in its final step until that register is free.
module can_bit_timing_search (
    input  wire              i_clk,
    input  wire              i_rst_n,
    cbts_in_if.sink          i_in,
    cbts_out_if.source       o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;

    localparam int DIV_CNT_W = $clog2(cbts_pkg::CLK_W);

    // Control state.
    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_zero;

    // Divider.
    logic [cbts_pkg::RATE_W-1:0] r_rem;
    logic [cbts_pkg::CLK_W-1:0]  r_num;
    logic [cbts_pkg::RATE_W-1:0] r_den;
    logic [cbts_pkg::RATE_W:0]   w_trial;
    logic [cbts_pkg::RATE_W:0]   w_diff;
    logic                        w_qbit;
    logic [cbts_pkg::RATE_W-1:0] n_rem;

    // Low bits of the quotient and a flag for anything above them.
    logic [cbts_pkg::TARGET_W-1:0] r_target;
    logic                          r_big;

    // One remainder and quotient lane for each quanta count.
    logic [cbts_pkg::TQ_W-1:0]  r_lane_rem [cbts_pkg::NUM_LANES];
    logic [cbts_pkg::PRE_W-1:0] r_lane_q   [cbts_pkg::NUM_LANES];
    logic [cbts_pkg::TQ_W-1:0]  n_lane_rem [cbts_pkg::NUM_LANES];
    logic [cbts_pkg::PRE_W-1:0] n_lane_q   [cbts_pkg::NUM_LANES];
    logic [cbts_pkg::NUM_LANES-1:0] w_lane_ok;

    // Selection.
    logic                        w_found;
    logic [cbts_pkg::LANE_W-1:0] w_sel;
    logic [cbts_pkg::TQ_W-1:0]   w_tq;
    logic [cbts_pkg::SEG1_W-1:0] w_s1;
    logic [cbts_pkg::TQ_W-1:0]   w_s2;
    logic [cbts_pkg::PRE_W-1:0]  w_pre;
    logic [cbts_pkg::PRE_W-1:0]  w_pre_m1;
    logic [cbts_pkg::SEG1_W-1:0] w_s1_m1;
    logic [cbts_pkg::TQ_W-1:0]   w_s2_m1;

    // Output register.
    logic                          r_out_valid;
    logic [cbts_pkg::STATUS_W-1:0] r_status;
    logic [cbts_pkg::PRE_W-1:0]    r_pre;
    logic [cbts_pkg::SEG1_W-1:0]   r_seg1;
    logic [cbts_pkg::SEG2_W-1:0]   r_seg2;
    logic [cbts_pkg::SJW_W-1:0]    r_sjw;
    logic [cbts_pkg::WORD_W-1:0]   r_word;

    logic w_in_acc;
    logic w_load;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_SEL) && (!r_out_valid || o_out.ready);

    // One restoring division step per cycle.
    always_comb begin
        w_trial = {r_rem, r_num[cbts_pkg::CLK_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_qbit  = (w_trial >= {1'b0, r_den});
        n_rem   = w_qbit ? w_diff[cbts_pkg::RATE_W-1:0] : w_trial[cbts_pkg::RATE_W-1:0];
    end

    // Each lane divides the quotient bit stream by its own quanta count.
    always_comb begin
        logic [cbts_pkg::TQ_W:0] t;
        logic [cbts_pkg::TQ_W:0] tq;
        for (int i = 0; i < cbts_pkg::NUM_LANES; i++) begin
            tq = (cbts_pkg::TQ_W + 1)'(cbts_pkg::QUANTA_MIN + i);
            t  = {r_lane_rem[i], w_qbit};
            if (t >= tq) begin
                n_lane_rem[i] = cbts_pkg::TQ_W'(t - tq);
                n_lane_q[i]   = {r_lane_q[i][cbts_pkg::PRE_W-2:0], 1'b1};
            end else begin
                n_lane_rem[i] = t[cbts_pkg::TQ_W-1:0];
                n_lane_q[i]   = {r_lane_q[i][cbts_pkg::PRE_W-2:0], 1'b0};
            end
        end
    end

    // A lane qualifies when it divides the target evenly with a prescaler in range.
    always_comb begin
        for (int i = 0; i < cbts_pkg::NUM_LANES; i++) begin
            w_lane_ok[i] = !r_big && (r_lane_rem[i] == '0) &&
                (r_target >= cbts_pkg::TARGET_W'(cbts_pkg::QUANTA_MIN + i)) &&
                (r_target <= cbts_pkg::TARGET_W'(
                    cbts_pkg::MAX_PRESCALER * (cbts_pkg::QUANTA_MIN + i))) &&
                (cbts_pkg::SEG_ONE_TAB[cbts_pkg::QUANTA_MIN + i] != '0);
        end
    end

    // The largest qualifying quanta count gives the smallest prescaler.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = 0; i < cbts_pkg::NUM_LANES; i++) begin
            if (w_lane_ok[i]) begin
                w_found = 1'b1;
                w_sel   = cbts_pkg::LANE_W'(i);
            end
        end
        w_tq     = cbts_pkg::TQ_W'(cbts_pkg::QUANTA_MIN) + cbts_pkg::TQ_W'(w_sel);
        w_s1     = cbts_pkg::SEG_ONE_TAB[w_tq];
        w_s2     = w_tq - cbts_pkg::TQ_W'(1) - cbts_pkg::TQ_W'(w_s1);
        w_pre    = r_lane_q[w_sel];
        w_pre_m1 = w_pre - cbts_pkg::PRE_W'(1);
        w_s1_m1  = w_s1 - cbts_pkg::SEG1_W'(1);
        w_s2_m1  = w_s2 - cbts_pkg::TQ_W'(1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.clock_hz == '0 || i_in.bit_rate == '0) ? S_SEL : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(cbts_pkg::CLK_W - 1)) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_num    <= i_in.clock_hz;
            r_den    <= i_in.bit_rate;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_zero   <= (i_in.clock_hz == '0 || i_in.bit_rate == '0);
            r_target <= '0;
            r_big    <= 1'b0;
            for (int i = 0; i < cbts_pkg::NUM_LANES; i++) begin
                r_lane_rem[i] <= '0;
            end
        end else if (r_state == S_DIV) begin
            r_num    <= {r_num[cbts_pkg::CLK_W-2:0], 1'b0};
            r_rem    <= n_rem;
            r_cnt    <= r_cnt + DIV_CNT_W'(1);
            r_target <= {r_target[cbts_pkg::TARGET_W-2:0], w_qbit};
            r_big    <= r_big | r_target[cbts_pkg::TARGET_W-1];
            for (int i = 0; i < cbts_pkg::NUM_LANES; i++) begin
                r_lane_rem[i] <= n_lane_rem[i];
                r_lane_q[i]   <= n_lane_q[i];
            end
        end

        // Result capture.
        if (w_load) begin
            if (r_zero || !w_found) begin
                r_status <= r_zero ? cbts_pkg::ST_ZERO : cbts_pkg::ST_NONE;
                r_pre    <= '0;
                r_seg1   <= '0;
                r_seg2   <= '0;
                r_sjw    <= '0;
                r_word   <= '0;
            end else begin
                r_status <= cbts_pkg::ST_FOUND;
                r_pre    <= w_pre;
                r_seg1   <= w_s1;
                r_seg2   <= cbts_pkg::SEG2_W'(w_s2);
                r_sjw    <= cbts_pkg::SJW_W'(1);
                r_word   <= {2'b00, 1'b0, w_s2_m1[2:0], w_s1_m1[3:0], 6'b000000,
                             w_pre_m1[9:0]};
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.prescaler   = r_pre;
    assign o_out.segment_one = r_seg1;
    assign o_out.segment_two = r_seg2;
    assign o_out.jump_width  = r_sjw;
    assign o_out.timing_word = r_word;

    // A request never starts a second one on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request channel ready right after a transaction");

    // A found timing always carries a nonzero prescaler and a unit jump width.
    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == cbts_pkg::ST_FOUND |->
            o_out.prescaler != '0 && o_out.jump_width == 1'b1 &&
            o_out.segment_one != '0 && o_out.segment_two != '0)
        else $error("found timing with an empty field");

    // Error results carry an empty timing word.
    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != cbts_pkg::ST_FOUND |->
            o_out.timing_word == '0 && o_out.prescaler == '0)
        else $error("error result with a nonzero timing");

endmodule

`default_nettype wire
